// File: rtl/core/dtc_pkg.sv
// shared constants, types and command codes of the decision tree classifier
package dtc_pkg;

  // tree and sample sizes
  localparam int TREE_LEVELS   = 8;
  localparam int FEATURE_COUNT = 16;
  localparam int SLOT_COUNT    = (1 << TREE_LEVELS) - 1;
  localparam int SLOT_W        = TREE_LEVELS;
  localparam int CHILD_W       = TREE_LEVELS + 1;
  localparam int FEAT_AW       = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

  // field widths
  localparam int CMD_W   = 2;
  localparam int FNUM_W  = 4;
  localparam int VALUE_W = 16;
  localparam int CLASS_W = 8;
  localparam int LEVEL_W = 4;

  // configuration port
  localparam int APB_AW             = 3;
  localparam int APB_DW             = 32;
  localparam int REG_IDX_W          = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_LEVELS = '0;
  localparam logic [LEVEL_W-1:0] LEVELS_RESET = LEVEL_W'(TREE_LEVELS);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_NODE     = 2'd0,
    CMD_WRITE_FEATURE = 2'd1,
    CMD_CLASSIFY      = 2'd2
  } cmd_t;

  // node payload held in the node memory
  typedef struct packed {
    logic [FNUM_W-1:0]         feature;
    logic signed [VALUE_W-1:0] threshold;
    logic [CLASS_W-1:0]        left_class;
    logic [CLASS_W-1:0]        right_class;
  } node_t;

  // node write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic              present;
    node_t             node;
  } node_wr_t;

endpackage

// File: rtl/core/dtc_node_store.sv
// node table: present flags in flops, node payload in a synchronous memory
module dtc_node_store
  import dtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  node_wr_t           wr,
  input  logic               rd_en,
  input  logic [SLOT_W-1:0]  rd_slot,
  output node_t              rd_node,
  input  logic [CHILD_W-1:0] chk_slot,
  input  logic [CHILD_W-1:0] chk_limit,
  output logic               chk_live
);

  logic [SLOT_COUNT-1:0] present_r;
  node_t                 node_mem [SLOT_COUNT];
  node_t                 rd_node_r;
  logic                  wr_ok;

  assign wr_ok = wr.en && (CHILD_W'(wr.slot) < CHILD_W'(SLOT_COUNT));

  // present flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr_ok) begin
      present_r[wr.slot] <= wr.present;
    end
  end

  // payload memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_ok && wr.present) begin
      node_mem[wr.slot] <= wr.node;
    end
    if (rd_en) begin
      rd_node_r <= node_mem[rd_slot];
    end
  end

  assign rd_node = rd_node_r;

  // slot lies within the levels in use and holds a node
  always_comb begin
    chk_live = 1'b0;
    if (chk_slot < chk_limit) begin
      chk_live = present_r[chk_slot[SLOT_W-1:0]];
    end
  end

endmodule

// File: rtl/core/decision_tree_classifier.sv
// top level of the decision tree classifier
//
// Commands enter on the in_ ports and are taken at a clock edge where start
// is high and busy is low. A node load fills one heap slot of the node table,
// write_feature stores one feature value of the current sample; both finish
// in the accepting cycle, produce no result, and busy stays low, so a write
// can be issued every cycle while no walk runs. classify walks the tree from
// the root and gives exactly one result: out_valid is high for one cycle with
// out_predicted_class and out_tree_empty. An empty tree answers in the cycle
// after acceptance. Otherwise each visited level steps through a node memory
// read, then a feature memory read and compare; busy is high while the walk
// runs and falls in the cycle the result shows. The receiver cannot stall:
// the result is taken in the cycle it is shown.
// levels_in_use is written over the APB port at byte address 0; the user must
// write it only while idle, the block itself does not enforce this.
// Synchronous reset clears all present flags, sets levels_in_use to 8 and
// returns to idle; feature values are undefined until written.
module decision_tree_classifier
  import dtc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          in_command,
  input  logic [SLOT_W-1:0]         in_node_slot,
  input  logic                      in_node_present,
  input  logic [FNUM_W-1:0]         in_feature_number,
  input  logic signed [VALUE_W-1:0] in_split_threshold,
  input  logic [CLASS_W-1:0]        in_left_leaf_class,
  input  logic [CLASS_W-1:0]        in_right_leaf_class,
  input  logic signed [VALUE_W-1:0] in_sample_value,
  // result channel
  output logic                      out_valid,
  output logic [CLASS_W-1:0]        out_predicted_class,
  output logic                      out_tree_empty,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE,
    ST_FEAT
  } state_t;

  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    cur_r, cur_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0]   out_class_r, out_class_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [LEVEL_W-1:0]   levels_r;

  logic [LEVEL_W-1:0]   levels_eff;
  logic [CHILD_W-1:0]   limit;
  logic                 accept;
  logic                 cfg_wr;

  node_wr_t             node_wr;
  logic                 node_rd_en;
  logic [SLOT_W-1:0]    node_rd_slot;
  node_t                node_rd;
  logic [CHILD_W-1:0]   chk_slot;
  logic                 chk_live;

  logic signed [VALUE_W-1:0] feat_mem [FEATURE_COUNT];
  logic signed [VALUE_W-1:0] feat_rd_r;
  logic                 feat_ok_r;
  logic                 feat_rd_en;
  logic                 feat_wr_en;
  logic signed [VALUE_W-1:0] feat_x;
  logic                 go_left;
  logic [CHILD_W-1:0]   child;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_RESET;
    end else if (cfg_wr && (paddr[APB_AW-1:2] == REG_LEVELS)) begin
      levels_r <= pwdata[LEVEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_LEVELS) begin
      prdata = APB_DW'(levels_r);
    end
  end

  // slots at or beyond 2^levels - 1 count as absent
  assign levels_eff = (levels_r > LEVEL_W'(TREE_LEVELS)) ? LEVEL_W'(TREE_LEVELS) : levels_r;
  assign limit      = (CHILD_W'(1) << levels_eff) - CHILD_W'(1);

  // node table writes
  always_comb begin
    node_wr.en                = accept && (in_command == CMD_LOAD_NODE);
    node_wr.slot              = in_node_slot;
    node_wr.present           = in_node_present;
    node_wr.node.feature      = in_feature_number;
    node_wr.node.threshold    = in_split_threshold;
    node_wr.node.left_class   = in_left_leaf_class;
    node_wr.node.right_class  = in_right_leaf_class;
  end

  // feature store
  assign feat_wr_en = accept && (in_command == CMD_WRITE_FEATURE) &&
                      (32'(in_feature_number) < FEATURE_COUNT);
  assign feat_rd_en = (state_r == ST_NODE);

  always_ff @(posedge clk) begin
    if (feat_wr_en) begin
      feat_mem[FEAT_AW'(in_feature_number)] <= in_sample_value;
    end
    if (feat_rd_en) begin
      feat_rd_r <= feat_mem[FEAT_AW'(node_rd.feature)];
      feat_ok_r <= (32'(node_rd.feature) < FEATURE_COUNT);
    end
  end

  // compare and pick the child
  assign feat_x  = feat_ok_r ? feat_rd_r : '0;
  assign go_left = feat_x < node_rd.threshold;
  assign child   = {cur_r, 1'b0} + (go_left ? CHILD_W'(1) : CHILD_W'(2));

  assign chk_slot     = (state_r == ST_FEAT) ? child : '0;
  assign node_rd_slot = (state_r == ST_FEAT) ? child[SLOT_W-1:0] : '0;

  dtc_node_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (node_wr),
    .rd_en     (node_rd_en),
    .rd_slot   (node_rd_slot),
    .rd_node   (node_rd),
    .chk_slot  (chk_slot),
    .chk_limit (limit),
    .chk_live  (chk_live)
  );

  // walk sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    out_class_nxt = out_class_r;
    out_empty_nxt = out_empty_r;
    node_rd_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_CLASSIFY)) begin
          if (chk_live) begin
            node_rd_en = 1'b1;
            cur_nxt    = '0;
            state_nxt  = ST_NODE;
          end else begin
            out_valid_nxt = 1'b1;
            out_class_nxt = '0;
            out_empty_nxt = 1'b1;
          end
        end
      end
      ST_NODE: begin
        state_nxt = ST_FEAT;
      end
      ST_FEAT: begin
        if (chk_live) begin
          node_rd_en = 1'b1;
          cur_nxt    = child[SLOT_W-1:0];
          state_nxt  = ST_NODE;
        end else begin
          out_valid_nxt = 1'b1;
          out_class_nxt = go_left ? node_rd.left_class : node_rd.right_class;
          out_empty_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      out_class_r <= '0;
      out_empty_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      out_class_r <= out_class_nxt;
      out_empty_r <= out_empty_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_class_r;
  assign out_tree_empty      = out_empty_r;

endmodule

// File: rtl/core/dtc_checker.sv
// port-level checks of the decision tree classifier and their bind
module dtc_checker
  import dtc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [CMD_W-1:0]   in_command,
  input logic               out_valid,
  input logic [CLASS_W-1:0] out_predicted_class,
  input logic               out_tree_empty,
  input logic               pready
);

  // an empty tree reports class zero
  a_empty_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tree_empty) |-> (out_predicted_class == '0))
    else $error("empty tree result with nonzero class");

  // a result ends the walk
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while walk still running");

  // a walk only starts from an accepted classify transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> ($past(start) && ($past(in_command) == CMD_CLASSIFY)))
    else $error("busy rose without a classify transaction");

  // write transactions finish at once and give no result
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_command == CMD_LOAD_NODE) ||
                        (in_command == CMD_WRITE_FEATURE))) |=> (!busy && !out_valid))
    else $error("write transaction left the block busy or gave a result");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind decision_tree_classifier dtc_checker u_dtc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_command          (in_command),
  .out_valid           (out_valid),
  .out_predicted_class (out_predicted_class),
  .out_tree_empty      (out_tree_empty),
  .pready              (pready)
);

// File: dv/decision_tree_classifier_tb.sv
// self-checking testbench for the decision tree classifier: directed and random command streams
`timescale 1ns / 100ps

module decision_tree_classifier_tb;
  import dtc_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [APB_AW-1:0] LEVELS_ADDR  = {REG_LEVELS, 2'b00};
  localparam int unsigned       WALK_SETTLE  = 24;
  localparam int unsigned       DRAIN_GUARD  = 4000;
  localparam int unsigned       RUN_LIMIT_NS = 4_000_000;
  localparam int unsigned       PHASE_QUOTA  = 110;

  // one command transaction
  typedef struct {
    logic [CMD_W-1:0]          command;
    logic [SLOT_W-1:0]         slot;
    logic                      present;
    logic [FNUM_W-1:0]         fnum;
    logic signed [VALUE_W-1:0] thresh;
    logic [CLASS_W-1:0]        lclass;
    logic [CLASS_W-1:0]        rclass;
    logic signed [VALUE_W-1:0] sample;
  } cmd_item_t;

  // outcome of one tree walk
  typedef struct {
    logic [CLASS_W-1:0] cls;
    logic               empty;
    int unsigned        depth;
  } walk_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [CMD_W-1:0]          in_command = '0;
  logic [SLOT_W-1:0]         in_node_slot = '0;
  logic                      in_node_present = 1'b0;
  logic [FNUM_W-1:0]         in_feature_number = '0;
  logic signed [VALUE_W-1:0] in_split_threshold = '0;
  logic [CLASS_W-1:0]        in_left_leaf_class = '0;
  logic [CLASS_W-1:0]        in_right_leaf_class = '0;
  logic signed [VALUE_W-1:0] in_sample_value = '0;
  logic                      out_valid;
  logic [CLASS_W-1:0]        out_predicted_class;
  logic                      out_tree_empty;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  // shadow of the block state
  node_t                     tree_nodes[SLOT_COUNT];
  bit                        node_live[SLOT_COUNT];
  logic signed [VALUE_W-1:0] sample_feats[FEATURE_COUNT];
  logic [LEVEL_W-1:0]        levels_reg = LEVELS_RESET;

  walk_result_t expected_classes[$];

  // sender pacing
  bit          start_held = 1'b0;
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 0;

  // run statistics
  int unsigned mismatches = 0;
  int unsigned n_items = 0;
  int unsigned n_ignored = 0;
  int unsigned n_classify = 0;
  int unsigned n_empty = 0;
  int unsigned deepest = 0;
  string       levels_seen = "";

  decision_tree_classifier dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_node_slot        (in_node_slot),
    .in_node_present     (in_node_present),
    .in_feature_number   (in_feature_number),
    .in_split_threshold  (in_split_threshold),
    .in_left_leaf_class  (in_left_leaf_class),
    .in_right_leaf_class (in_right_leaf_class),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_predicted_class (out_predicted_class),
    .out_tree_empty      (out_tree_empty),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #4 clk = ~clk;

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit slot_in_use(int unsigned slot, int unsigned limit);
    return slot < limit && slot < SLOT_COUNT && node_live[slot];
  endfunction

  // walk from the root as the block does
  function automatic walk_result_t walk_tree();
    int unsigned  lv;
    int unsigned  limit;
    int unsigned  cur;
    int unsigned  child;
    logic         go_left;
    node_t        n;
    walk_result_t r;
    r.cls = '0;
    r.empty = 1'b0;
    r.depth = 0;
    lv = (levels_reg > TREE_LEVELS) ? TREE_LEVELS : levels_reg;
    limit = (1 << lv) - 1;
    if (!slot_in_use(0, limit)) begin
      r.empty = 1'b1;
      return r;
    end
    cur = 0;
    for (int level = 0; level < TREE_LEVELS; level++) begin
      n = tree_nodes[cur];
      r.depth = level + 1;
      go_left = $signed(sample_feats[n.feature]) < $signed(n.threshold);
      child = 2 * cur + (go_left ? 1 : 2);
      if (slot_in_use(child, limit)) begin
        cur = child;
      end else begin
        r.cls = go_left ? n.left_class : n.right_class;
        break;
      end
    end
    return r;
  endfunction

  // update the shadow state for one accepted transaction
  function automatic void apply_item(cmd_item_t it);
    walk_result_t r;
    case (it.command)
      CMD_LOAD_NODE: begin
        if (it.slot < SLOT_COUNT) begin
          n_items++;
          node_live[it.slot] = it.present;
          if (it.present)
            tree_nodes[it.slot] = '{feature: it.fnum, threshold: it.thresh,
                                    left_class: it.lclass, right_class: it.rclass};
          else
            tree_nodes[it.slot] = '0;
        end else begin
          n_ignored++;
        end
      end
      CMD_WRITE_FEATURE: begin
        n_items++;
        sample_feats[it.fnum] = it.sample;
      end
      CMD_CLASSIFY: begin
        n_items++;
        r = walk_tree();
        n_classify++;
        if (r.empty) n_empty++;
        if (r.depth > deepest) deepest = r.depth;
        expected_classes.push_back(r);
      end
      default: n_ignored++;
    endcase
  endfunction

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && out_valid) begin
      if (expected_classes.size() == 0) begin
        $error("unexpected result: predicted_class %0d, tree_empty %0d",
               out_predicted_class, out_tree_empty);
        mismatches++;
      end else begin
        want = expected_classes.pop_front();
        if (out_predicted_class !== want.cls) begin
          $error("predicted_class: expected %0d, actual %0d", want.cls, out_predicted_class);
          mismatches++;
        end
        if (out_tree_empty !== want.empty) begin
          $error("tree_empty: expected %0d, actual %0d", want.empty, out_tree_empty);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  // mostly full range, with extremes and near-zero values so compares hit equality
  function automatic logic signed [VALUE_W-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4, 5, 6: return VALUE_W'($signed($urandom_range(0, 6)) - 3);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // equal weight per tree level, rarely the slot beyond the table
  function automatic logic [SLOT_W-1:0] rand_slot();
    int unsigned depth;
    if ($urandom_range(0, 31) == 0) return SLOT_W'(SLOT_COUNT);
    depth = $urandom_range(0, TREE_LEVELS - 1);
    return SLOT_W'((1 << depth) - 1 + $urandom_range(0, (1 << depth) - 1));
  endfunction

  function automatic cmd_item_t rand_item(logic [CMD_W-1:0] cmd);
    cmd_item_t it;
    it.command = cmd;
    it.slot    = SLOT_W'($urandom);
    it.present = 1'($urandom);
    it.fnum    = FNUM_W'($urandom);
    it.thresh  = rand_value();
    it.lclass  = CLASS_W'($urandom);
    it.rclass  = CLASS_W'($urandom);
    it.sample  = rand_value();
    return it;
  endfunction

  function automatic cmd_item_t node_item(logic [SLOT_W-1:0] slot, logic present,
                                          logic [FNUM_W-1:0] fnum,
                                          logic signed [VALUE_W-1:0] thresh,
                                          logic [CLASS_W-1:0] lclass,
                                          logic [CLASS_W-1:0] rclass);
    cmd_item_t it;
    it = rand_item(CMD_LOAD_NODE);
    it.slot    = slot;
    it.present = present;
    it.fnum    = fnum;
    it.thresh  = thresh;
    it.lclass  = lclass;
    it.rclass  = rclass;
    return it;
  endfunction

  function automatic cmd_item_t feature_item(logic [FNUM_W-1:0] fnum,
                                             logic signed [VALUE_W-1:0] value);
    cmd_item_t it;
    it = rand_item(CMD_WRITE_FEATURE);
    it.fnum   = fnum;
    it.sample = value;
    return it;
  endfunction

  // drive one transaction, wait for acceptance, then keep start up or open a gap
  task automatic send_item(cmd_item_t it);
    in_command          <= it.command;
    in_node_slot        <= it.slot;
    in_node_present     <= it.present;
    in_feature_number   <= it.fnum;
    in_split_threshold  <= it.thresh;
    in_left_leaf_class  <= it.lclass;
    in_right_leaf_class <= it.rclass;
    in_sample_value     <= it.sample;
    start               <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    apply_item(it);
    if (!gaps_on || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
      start_held = 1'b1;
    end else begin
      start <= 1'b0;
      start_held = 1'b0;
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(8, 24)) @(posedge clk);
      else
        repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic release_input();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  // wait for every outstanding classification, then let a possible walk finish
  task automatic wait_idle();
    int unsigned guard;
    release_input();
    guard = 0;
    while (expected_classes.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (WALK_SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_levels(logic [LEVEL_W-1:0] value);
    logic [APB_DW-1:0] rd;
    apb_read(LEVELS_ADDR, rd);
    if (rd[LEVEL_W-1:0] !== value) begin
      $error("levels_in_use readback: expected %0d, actual %0d", value, rd[LEVEL_W-1:0]);
      mismatches++;
    end
  endtask

  // reprogram the depth register between phases
  task automatic set_levels(logic [LEVEL_W-1:0] value);
    wait_idle();
    apb_write(LEVELS_ADDR, APB_DW'(value));
    levels_reg = value;
    levels_seen = $sformatf("%s %0d", levels_seen, value);
    check_levels(value);
  endtask

  // a chain of present nodes from the root down to the last level
  task automatic build_path();
    cmd_item_t   it;
    int unsigned slot;
    slot = 0;
    for (int d = 0; d < TREE_LEVELS; d++) begin
      it = rand_item(CMD_LOAD_NODE);
      it.slot    = SLOT_W'(slot);
      it.present = 1'b1;
      send_item(it);
      slot = 2 * slot + $urandom_range(1, 2);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // register and node table right after reset
  task automatic test_reset_state();
    check_levels(LEVELS_RESET);
    send_item(rand_item(CMD_CLASSIFY));
  endtask

  // leaf choice, threshold equality, clearing and ignored writes
  task automatic test_leaf_choice();
    send_item(feature_item(4'd0, 16'sh8000));
    send_item(feature_item(4'd15, 16'sh7FFF));
    send_item(feature_item(4'd7, 16'sh0100));
    // feature equal to threshold goes right
    send_item(node_item(8'd0, 1'b1, 4'd15, 16'sh7FFF, 8'hAA, 8'h55));
    send_item(rand_item(CMD_CLASSIFY));
    // most negative against most negative, right leaf class zero
    send_item(node_item(8'd2, 1'b1, 4'd0, 16'sh8000, 8'hFF, 8'h00));
    send_item(rand_item(CMD_CLASSIFY));
    // one lsb below threshold goes left
    send_item(node_item(8'd0, 1'b1, 4'd7, 16'sh0101, 8'h01, 8'hFE));
    send_item(rand_item(CMD_CLASSIFY));
    send_item(node_item(SLOT_W'(SLOT_COUNT - 1), 1'b1, 4'd15, 16'sh0000, 8'h12, 8'h34));
    send_item(node_item(SLOT_W'(SLOT_COUNT), 1'b1, 4'd0, 16'sh0000, 8'h77, 8'h77));
    send_item(rand_item(CMD_UNUSED));
    // clearing wipes the slot even with nonzero fields
    send_item(node_item(8'd2, 1'b0, 4'd15, 16'sh7FFF, 8'hFF, 8'hFF));
    send_item(node_item(8'd0, 1'b1, 4'd15, 16'sh7FFF, 8'hAA, 8'h55));
    send_item(rand_item(CMD_CLASSIFY));
    send_item(node_item(8'd0, 1'b0, 4'd7, 16'sh0101, 8'h01, 8'hFE));
    send_item(rand_item(CMD_CLASSIFY));
  endtask

  // depth register at zero, one and above the table depth
  task automatic test_levels_extremes();
    send_item(node_item(8'd0, 1'b1, 4'd15, 16'sh0000, 8'h11, 8'h22));
    send_item(node_item(8'd2, 1'b1, 4'd0, 16'sh0000, 8'h5A, 8'hA5));
    set_levels(4'd0);
    send_item(rand_item(CMD_CLASSIFY));
    set_levels(4'd1);
    send_item(rand_item(CMD_CLASSIFY));
    set_levels(4'd15);
    send_item(rand_item(CMD_CLASSIFY));
  endtask

  // every slot present, so walks run the full depth
  task automatic test_full_tree();
    cmd_item_t it;
    set_levels(LEVELS_RESET);
    for (int f = 0; f < FEATURE_COUNT; f++)
      send_item(feature_item(FNUM_W'(f), rand_value()));
    for (int s = 0; s < SLOT_COUNT; s++) begin
      it = rand_item(CMD_LOAD_NODE);
      it.slot    = SLOT_W'(s);
      it.present = 1'b1;
      send_item(it);
    end
    for (int k = 0; k < 120; k++) begin
      repeat ($urandom_range(0, 3)) send_item(rand_item(CMD_WRITE_FEATURE));
      send_item(rand_item(CMD_CLASSIFY));
    end
  endtask

  // mixed traffic over a series of depth settings
  task automatic test_random_phases();
    logic [LEVEL_W-1:0] phase_levels[11] = '{3, 1, 15, 5, 0, 7, 9, 2, 8, 4, 6};
    cmd_item_t          it;
    int unsigned        target;
    int unsigned        pick;
    foreach (phase_levels[p]) begin
      set_levels(phase_levels[p]);
      gaps_on = (p % 3) != 2;
      burst_left = 0;
      target = n_items + PHASE_QUOTA;
      while (n_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          build_path();
        end else begin
          if (pick < 32) begin
            it = rand_item(CMD_LOAD_NODE);
            it.slot    = rand_slot();
            it.present = $urandom_range(0, 4) != 0;
          end else if (pick < 55) begin
            it = rand_item(CMD_WRITE_FEATURE);
          end else if (pick < 96) begin
            it = rand_item(CMD_CLASSIFY);
          end else begin
            it = rand_item(CMD_UNUSED);
          end
          send_item(it);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    foreach (node_live[s]) begin
      node_live[s] = 1'b0;
      tree_nodes[s] = '0;
    end
    foreach (sample_feats[f]) sample_feats[f] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_leaf_choice();
    test_levels_extremes();
    test_full_tree();
    test_random_phases();

    wait_idle();
    $display("covered %0d transactions (%0d ignored), %0d classifications, %0d on empty tree",
             n_items, n_ignored, n_classify, n_empty);
    $display("walks up to %0d levels, levels_in_use settings:%s", deepest, levels_seen);
    if (mismatches == 0 && expected_classes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (expected_classes.size() != 0)
        $error("%0d classifications never answered", expected_classes.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
